/* rtl/gray_histogram_normalizer_assert.svh */
// ----------------------------------------------------------------------------
// gray_histogram_normalizer_assert.svh
// Assertion macros used by the checker file of the histogram block.
// ----------------------------------------------------------------------------
`ifndef GRAY_HISTOGRAM_NORMALIZER_ASSERT_SVH
`define GRAY_HISTOGRAM_NORMALIZER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define GHN_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, disabled while reset is low
`define GHN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

/* rtl/ghn_pkg.sv */
// ----------------------------------------------------------------------------
// ghn_pkg
// Shared constants, types and helpers of the gray-level histogram block.
// ----------------------------------------------------------------------------
`default_nettype none

package ghn_pkg;

    localparam int BIN_COUNT   = 256;
    localparam int COUNT_WIDTH = 21;
    localparam int BIN_W       = $clog2(BIN_COUNT);
    localparam int PIX_W       = 8;
    localparam int HEIGHT_W    = 7;
    localparam int OUT_COUNT_W = 21;
    localparam int SCALE_TOP   = 100;
    localparam int DIV_W       = COUNT_WIDTH + HEIGHT_W;
    localparam int STEP_W      = $clog2(HEIGHT_W);
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 1'b1;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ACCUM = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    function automatic logic f_in_bins(input logic [PIX_W-1:0] v);
        return (int'(v) < BIN_COUNT);
    endfunction

    function automatic logic [BIN_W-1:0] f_bin_addr(input logic [PIX_W-1:0] v);
        return BIN_W'(v);
    endfunction

endpackage

`default_nettype wire

/* rtl/gray_histogram_normalizer.sv */
// A read fetches the bin word from RAM, loads the divider and registers its word
// when the divider is done; accumulate is one read-modify-write of the bin RAM.
// The divider runs 7 compare-subtract steps, one a cycle, and cannot be stalled.
// Results cannot be stalled; o_valid strobes for one cycle per read.
// Reset (synchronous, active low) empties the histogram at once through
// per-bin valid bits, zeroes the peak and both range registers.
// ----------------------------------------------------------------------------
// gray_histogram_normalizer
// 256-bin gray-level histogram with peak tracking and 0..100 bar read-out.
// ----------------------------------------------------------------------------
`default_nettype none

module gray_histogram_normalizer import ghn_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  start,
    input  wire logic [1:0]            i_action,
    input  wire logic [PIX_W-1:0]      i_pixel_value,
    input  wire logic [PIX_W-1:0]      i_bin_select,
    output logic                       busy,
    output logic                       o_valid,
    output logic      [PIX_W-1:0]      o_bin_index,
    output logic      [HEIGHT_W-1:0]   o_bar_height,
    output logic                       o_in_range,
    output logic      [OUT_COUNT_W-1:0] o_bin_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_LOAD,
        S_DIV
    } t_state;

    t_state                 r_state;
    logic [PIX_W-1:0]       r_range_low;
    logic [PIX_W-1:0]       r_range_high;
    logic [BIN_COUNT-1:0]   r_valid;
    logic [COUNT_WIDTH-1:0] r_peak;
    logic [BIN_W-1:0]       r_addr;
    logic                   r_ok;
    logic                   r_hit;
    logic [PIX_W-1:0]       r_sel;
    logic                   r_in_range;
    logic [COUNT_WIDTH-1:0] r_cnt;

    logic                   r_out_valid;
    logic [PIX_W-1:0]       r_out_index;
    logic [HEIGHT_W-1:0]    r_out_height;
    logic                   r_out_in_range;
    logic [OUT_COUNT_W-1:0] r_out_count;

    logic                   accept;
    logic [BIN_W-1:0]       ram_raddr;
    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic [COUNT_WIDTH-1:0] cur_cnt;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic                   ram_we;
    logic                   div_done;
    logic [HEIGHT_W-1:0]    div_quot;

    assign accept    = start && (r_state == S_IDLE);
    assign ram_raddr = (t_action'(i_action) == ACT_ACCUM) ? f_bin_addr(i_pixel_value)
                                                          : f_bin_addr(i_bin_select);

    // a bin never written since the last clear reads as zero
    assign cur_cnt = (r_hit && r_ok) ? ram_rdata : '0;
    assign cnt_inc = cur_cnt + 1'b1;
    assign ram_we  = (r_state == S_ACC) && r_ok && (cur_cnt != COUNT_LIMIT);

    ghn_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (BIN_COUNT)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (cnt_inc),
        .i_re    (accept),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ghn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_LOAD),
        .i_count (cur_cnt),
        .i_peak  (r_peak),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_peak       <= '0;
            r_range_low  <= '0;
            r_range_high <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RANGE_LOW:  r_range_low  <= i_cfg_data;
                    CFG_RANGE_HIGH: r_range_high <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_sel      <= i_bin_select;
                        r_in_range <= (i_bin_select >= r_range_low) &&
                                      (i_bin_select <= r_range_high);
                        case (t_action'(i_action))
                            ACT_CLEAR: begin
                                r_valid <= '0;
                                r_peak  <= '0;
                            end
                            ACT_ACCUM: begin
                                r_ok    <= f_in_bins(i_pixel_value);
                                r_addr  <= f_bin_addr(i_pixel_value);
                                r_hit   <= r_valid[f_bin_addr(i_pixel_value)];
                                r_state <= S_ACC;
                            end
                            ACT_READ: begin
                                r_ok    <= f_in_bins(i_bin_select);
                                r_hit   <= r_valid[f_bin_addr(i_bin_select)];
                                r_state <= S_LOAD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_ACC: begin
                    if (ram_we) begin
                        r_valid[r_addr] <= 1'b1;
                        if (cnt_inc > r_peak) begin
                            r_peak <= cnt_inc;
                        end
                    end
                    r_state <= S_IDLE;
                end
                S_LOAD: begin
                    r_cnt   <= cur_cnt;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_out_index    <= r_sel;
                        r_out_height   <= (r_peak == '0) ? '0 : div_quot;
                        r_out_in_range <= r_in_range;
                        r_out_count    <= OUT_COUNT_W'(r_cnt);
                        r_out_valid    <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_bin_index  = r_out_index;
    assign o_bar_height = r_out_height;
    assign o_in_range   = r_out_in_range;
    assign o_bin_count  = r_out_count;

endmodule

`default_nettype wire

/* rtl/ghn_ram.sv */
// ----------------------------------------------------------------------------
// ghn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ghn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/ghn_div.sv */
// ----------------------------------------------------------------------------
// ghn_div
// Scales a count by 100 and divides it by the peak, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ghn_div import ghn_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [COUNT_WIDTH-1:0] i_count,
    input  wire logic [COUNT_WIDTH-1:0] i_peak,
    output logic                        o_done,
    output logic      [HEIGHT_W-1:0]    o_quot
);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [DIV_W-1:0]    r_rem;
    logic [DIV_W-1:0]    r_dvs;
    logic [HEIGHT_W-1:0] r_quot;

    logic                n_ge;
    logic [DIV_W-1:0]    n_diff;

    // count <= peak, so the quotient never exceeds 100 and fits HEIGHT_W bits
    assign n_ge   = (r_rem >= r_dvs);
    assign n_diff = r_rem - r_dvs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= DIV_W'(i_count) * DIV_W'(SCALE_TOP);
                r_dvs  <= DIV_W'(i_peak) << (HEIGHT_W - 1);
                r_step <= STEP_W'(HEIGHT_W - 1);
                r_quot <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (n_ge) begin
                    r_rem <= n_diff;
                end
                r_quot <= {r_quot[HEIGHT_W-2:0], n_ge};
                r_dvs  <= r_dvs >> 1;
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

/* rtl/ghn_chk.sv */
// ----------------------------------------------------------------------------
// ghn_chk
// Port-level checks on the histogram block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gray_histogram_normalizer_assert.svh"

module ghn_chk import ghn_pkg::*; (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   start,
    input wire logic                   busy,
    input wire logic [1:0]             i_action,
    input wire logic                   o_valid,
    input wire logic [HEIGHT_W-1:0]    o_bar_height,
    input wire logic [OUT_COUNT_W-1:0] o_bin_count
);

    logic take_read;
    logic take_other;

    assign take_read  = start && !busy && (t_action'(i_action) == ACT_READ);
    assign take_other = start && !busy && (t_action'(i_action) != ACT_READ);

    // word strobes never run back to back
    `GHN_ASSERT_NEXT(a_strobe_single, o_valid, !o_valid)
    // only a read makes a word
    `GHN_ASSERT_NEXT(a_no_word_on_other, take_other, !o_valid)
    // a read holds the block off while the divider runs
    `GHN_ASSERT_NEXT(a_read_goes_busy, take_read, busy)
    // bar is scaled to 0..100
    `GHN_ASSERT_NOW(a_bar_bound, o_valid, o_bar_height <= HEIGHT_W'(SCALE_TOP))
    // an empty bin has no bar
    `GHN_ASSERT_NOW(a_empty_bar, o_valid && (o_bin_count == '0), o_bar_height == '0)

endmodule

bind gray_histogram_normalizer ghn_chk u_ghn_chk (.*);

`default_nettype wire
